// ===== hw/rtl/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("implication failed");
`endif

// ===== hw/rtl/teq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package teq_pkg;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_BITS_DEF = 16;
    localparam int TIME_W = 63;
    localparam logic [TIME_W-1:0] LIMIT_RESET = 63'd86400000000000000;
    localparam logic [1:0] K_SCHED = 2'd0;
    localparam logic [1:0] K_CANCEL = 2'd1;
    localparam logic [1:0] K_NEXT = 2'd2;
    localparam logic [2:0] ST_SCHEDULED = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FIRED = 3'd4;
    localparam logic [2:0] ST_LIMIT = 3'd5;
    localparam logic [2:0] ST_EMPTY = 3'd6;
    typedef struct packed {
        logic load;
        logic clr_pos;
        logic ld_tail;
        logic inc_pos;
        logic rd_ord;
        logic rd_prev;
        logic rd_ent;
        logic shift_up;
        logic shift_dn;
        logic ins;
        logic drop_cnt;
        logic set_now_head;
        logic set_now_lim;
        logic done;
        logic [2:0] status;
    } t_cmd;
    typedef struct packed {
        logic [1:0] kind;
        logic full;
        logic empty;
        logic h_valid;
        logic pos_end;
        logic pos_zero;
        logic le;
        logic match;
        logic head_lim;
    } t_sts;
endpackage
`default_nettype wire

// ===== hw/rtl/teq_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module teq_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic [62:0] i_cfg_data,
    input  wire logic [1:0] i_kind,
    input  wire logic [62:0] i_event_time,
    input  wire logic [15:0] i_event_tag,
    input  wire logic [3:0] i_handle,
    input  wire teq_pkg::t_cmd i_cmd,
    output teq_pkg::t_sts o_sts,
    output logic o_strobe,
    output logic [2:0] o_status,
    output logic [3:0] o_slot,
    output logic [62:0] o_fired_time,
    output logic [15:0] o_fired_tag,
    output logic [62:0] o_now_time,
    output logic [4:0] o_pending
);
    import teq_pkg::*;
    localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [62:0] r_etime [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] r_etag [QUEUE_DEPTH];
    logic [SW-1:0] r_ord [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] r_valid;
    logic [CW-1:0] r_cnt, r_pos;
    logic [62:0] r_now, r_limit, r_t;
    logic [TAG_BITS-1:0] r_tag;
    logic [1:0] r_kind;
    logic [3:0] r_h;
    logic [SW-1:0] r_free, r_oslot, r_ordrd;
    logic [62:0] r_rtime;
    logic [TAG_BITS-1:0] r_rtag;
    logic r_strobe;
    logic [2:0] r_status;
    logic [3:0] r_slot;
    logic [62:0] r_ftime;
    logic [15:0] r_ftag;

    logic [SW-1:0] free_idx;
    logic free_any;
    logic [SW-1:0] pos_i, pos_m1;
    logic h_in;
    logic [31:0] tag_ext;

    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_idx = SW'(k);
                free_any = 1'b1;
            end
        end
    end

    assign pos_i = r_pos[SW-1:0];
    assign pos_m1 = SW'(r_pos - CW'(1));
    assign h_in = (32'(r_h) < 32'(QUEUE_DEPTH));
    assign tag_ext = 32'(r_rtag);

    assign o_sts.kind = r_kind;
    assign o_sts.full = (r_cnt >= CW'(QUEUE_DEPTH)) || !free_any;
    assign o_sts.empty = (r_cnt == '0);
    assign o_sts.h_valid = h_in && r_valid[SW'(r_h)];
    assign o_sts.pos_end = (r_pos >= r_cnt);
    assign o_sts.pos_zero = (r_pos == '0);
    assign o_sts.le = (r_rtime <= r_t);
    assign o_sts.match = (32'(r_ordrd) == 32'(r_h));
    assign o_sts.head_lim = (r_rtime >= r_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_cnt <= '0;
            r_now <= '0;
            r_limit <= LIMIT_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.done;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.ins) begin
                r_ord[pos_i] <= r_free;
                r_etime[r_free] <= r_t;
                r_etag[r_free] <= r_tag;
                r_valid[r_free] <= 1'b1;
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.drop_cnt) begin
                r_cnt <= r_cnt - CW'(1);
                r_valid[r_oslot] <= 1'b0;
            end
            if (i_cmd.set_now_head) begin
                r_now <= r_rtime;
            end
            if (i_cmd.set_now_lim) begin
                r_now <= r_limit;
            end
            if (i_cmd.shift_up) begin
                r_ord[pos_i] <= r_ord[pos_m1];
            end
            if (i_cmd.shift_dn) begin
                r_ord[pos_i] <= r_ord[SW'(r_pos + CW'(1))];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_t <= i_event_time;
            r_tag <= TAG_BITS'(i_event_tag);
            r_h <= i_handle;
            r_free <= free_idx;
        end
        if (i_cmd.clr_pos) begin
            r_pos <= '0;
        end else if (i_cmd.ld_tail) begin
            r_pos <= r_cnt;
        end else if (i_cmd.inc_pos) begin
            r_pos <= r_pos + CW'(1);
        end else if (i_cmd.shift_up) begin
            r_pos <= r_pos - CW'(1);
        end
        if (i_cmd.rd_ord) begin
            r_ordrd <= r_ord[pos_i];
        end else if (i_cmd.rd_prev) begin
            r_ordrd <= r_ord[pos_m1];
        end
        if (i_cmd.rd_ent) begin
            r_oslot <= r_ordrd;
            r_rtime <= r_etime[r_ordrd];
            r_rtag <= r_etag[r_ordrd];
        end
        if (i_cmd.done) begin
            r_status <= i_cmd.status;
            r_slot <= 4'(i_cmd.status == ST_SCHEDULED ? r_free :
                         (i_cmd.status == ST_FIRED ? r_oslot : '0));
            r_ftime <= (i_cmd.status == ST_FIRED) ? r_rtime : '0;
            r_ftag <= (i_cmd.status == ST_FIRED) ? tag_ext[15:0] : '0;
        end
    end

    assign o_strobe = r_strobe;
    assign o_status = r_status;
    assign o_slot = r_slot;
    assign o_fired_time = r_ftime;
    assign o_fired_tag = r_ftag;
    assign o_now_time = r_now;
    assign o_pending = 5'(r_cnt);

    `include "assert_macros.svh"
    `ASSERT_CLK(a_cnt_range, i_clk, i_rst_n, r_cnt <= CW'(QUEUE_DEPTH))
    `ASSERT_IMPL(a_cnt_valid, i_clk, i_rst_n, r_strobe, 32'($countones(r_valid)) == 32'(r_cnt))
    `ASSERT_IMPL(a_one_op, i_clk, i_rst_n, i_cmd.ins, !i_cmd.drop_cnt && !i_cmd.shift_dn)
endmodule
`default_nettype wire

// ===== hw/rtl/teq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module teq_ctrl (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire teq_pkg::t_sts i_sts,
    output teq_pkg::t_cmd o_cmd,
    output logic o_busy
);
    import teq_pkg::*;
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_SRD = 4'd2;
    localparam logic [3:0] S_SENT = 4'd3;
    localparam logic [3:0] S_SCMP = 4'd4;
    localparam logic [3:0] S_SINS = 4'd6;
    localparam logic [3:0] S_CRD = 4'd7;
    localparam logic [3:0] S_CCMP = 4'd8;
    localparam logic [3:0] S_DROP = 4'd9;
    localparam logic [3:0] S_NRD = 4'd10;
    localparam logic [3:0] S_NENT = 4'd11;
    localparam logic [3:0] S_NDEC = 4'd12;

    logic [3:0] r_state, n_state;
    logic r_fire, n_fire;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        n_fire = r_fire;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.kind)
                    K_SCHED: begin
                        if (i_sts.full) begin
                            o_cmd.done = 1'b1;
                            o_cmd.status = ST_FULL;
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.ld_tail = 1'b1;
                            n_state = S_SRD;
                        end
                    end
                    K_CANCEL: begin
                        o_cmd.clr_pos = 1'b1;
                        if (!i_sts.h_valid) begin
                            o_cmd.done = 1'b1;
                            o_cmd.status = ST_NOT_FOUND;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_CRD;
                        end
                    end
                    K_NEXT: begin
                        o_cmd.clr_pos = 1'b1;
                        if (i_sts.empty) begin
                            o_cmd.done = 1'b1;
                            o_cmd.status = ST_EMPTY;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_NRD;
                        end
                    end
                    default: begin
                        o_cmd.done = 1'b1;
                        o_cmd.status = ST_NOT_FOUND;
                        n_state = S_IDLE;
                    end
                endcase
            end
            // walk from the tail, moving later entries up one place
            S_SRD: begin
                if (i_sts.pos_zero) begin
                    n_state = S_SINS;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state = S_SENT;
                end
            end
            S_SENT: begin
                o_cmd.rd_ent = 1'b1;
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (i_sts.le) begin
                    n_state = S_SINS;
                end else begin
                    o_cmd.shift_up = 1'b1;
                    n_state = S_SRD;
                end
            end
            S_SINS: begin
                o_cmd.ins = 1'b1;
                o_cmd.done = 1'b1;
                o_cmd.status = ST_SCHEDULED;
                n_state = S_IDLE;
            end
            S_CRD: begin
                o_cmd.rd_ord = 1'b1;
                n_state = S_CCMP;
            end
            S_CCMP: begin
                if (i_sts.match) begin
                    o_cmd.rd_ent = 1'b1;
                    n_fire = 1'b0;
                    n_state = S_DROP;
                end else if (i_sts.pos_end) begin
                    o_cmd.done = 1'b1;
                    o_cmd.status = ST_NOT_FOUND;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.inc_pos = 1'b1;
                    n_state = S_CRD;
                end
            end
            S_NRD: begin
                o_cmd.rd_ord = 1'b1;
                n_state = S_NENT;
            end
            S_NENT: begin
                o_cmd.rd_ent = 1'b1;
                n_state = S_NDEC;
            end
            S_NDEC: begin
                if (i_sts.head_lim) begin
                    o_cmd.set_now_lim = 1'b1;
                    o_cmd.done = 1'b1;
                    o_cmd.status = ST_LIMIT;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.set_now_head = 1'b1;
                    n_fire = 1'b1;
                    n_state = S_DROP;
                end
            end
            S_DROP: begin
                if (i_sts.pos_end) begin
                    o_cmd.drop_cnt = 1'b1;
                    o_cmd.done = 1'b1;
                    o_cmd.status = r_fire ? ST_FIRED : ST_CANCELLED;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.shift_dn = 1'b1;
                    o_cmd.inc_pos = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fire <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fire <= n_fire;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_cmd.done, n_state == S_IDLE)
    `ASSERT_IMPL(a_load_idle, i_clk, i_rst_n, o_cmd.load, r_state == S_IDLE)
    `ASSERT_IMPL(a_busy, i_clk, i_rst_n, i_start && !o_busy, ##1 o_busy)
endmodule
`default_nettype wire

// ===== hw/rtl/timed_event_queue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   | handshake          | payload
// item in   | i_start & !o_busy  | i_kind i_event_time i_event_tag i_handle
// result    | o_strobe           | o_status o_slot o_fired_time o_fired_tag o_now_time o_pending
// config    | i_cfg_we           | i_cfg_data
// After acceptance, a rejected item ends at dispatch; schedule compares entries from
// the tail, moving each later one up, and inserts at its place or at the head; cancel
// searches from the head, then closes up behind the match; take next stops at the
// limit, else fires the head and closes up. The strobe follows the last busy cycle.
// Reset is synchronous; results show for one cycle and cannot stall.
module timed_event_queue_unit #(
    parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS = teq_pkg::TAG_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output logic o_busy,
    input  wire logic i_cfg_we,
    input  wire logic [62:0] i_cfg_data,
    input  wire logic [1:0] i_kind,
    input  wire logic [62:0] i_event_time,
    input  wire logic [15:0] i_event_tag,
    input  wire logic [3:0] i_handle,
    output logic o_strobe,
    output logic [2:0] o_status,
    output logic [3:0] o_slot,
    output logic [62:0] o_fired_time,
    output logic [15:0] o_fired_tag,
    output logic [62:0] o_now_time,
    output logic [4:0] o_pending
);
    import teq_pkg::*;
    t_cmd cmd;
    t_sts sts;

    teq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
        .i_sts(sts), .o_cmd(cmd), .o_busy(o_busy)
    );
    teq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .TAG_BITS(TAG_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .i_kind(i_kind), .i_event_time(i_event_time),
        .i_event_tag(i_event_tag), .i_handle(i_handle), .i_cmd(cmd), .o_sts(sts),
        .o_strobe(o_strobe), .o_status(o_status), .o_slot(o_slot),
        .o_fired_time(o_fired_time), .o_fired_tag(o_fired_tag),
        .o_now_time(o_now_time), .o_pending(o_pending)
    );
endmodule
`default_nettype wire

// ===== dv/timed_event_queue_unit_tb.sv =====
`timescale 1ns / 1ps
module timed_event_queue_unit_tb;
    import teq_pkg::*;

    localparam int DEPTH = 16;
    localparam longint unsigned CYCLE_LIMIT = 400000;
    localparam logic [1:0] K_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [62:0] event_time;
        logic [15:0] event_tag;
        logic [3:0]  handle;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [62:0] fired_time;
        logic [15:0] fired_tag;
        logic [62:0] now_time;
        logic [4:0]  pending;
    } resp_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [62:0] i_cfg_data = '0;
    logic [1:0]  i_kind = '0;
    logic [62:0] i_event_time = '0;
    logic [15:0] i_event_tag = '0;
    logic [3:0]  i_handle = '0;
    logic        o_busy, o_strobe;
    logic [2:0]  o_status;
    logic [3:0]  o_slot;
    logic [62:0] o_fired_time, o_now_time;
    logic [15:0] o_fired_tag;
    logic [4:0]  o_pending;

    timed_event_queue_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_kind(i_kind), .i_event_time(i_event_time), .i_event_tag(i_event_tag),
        .i_handle(i_handle), .o_strobe(o_strobe), .o_status(o_status),
        .o_slot(o_slot), .o_fired_time(o_fired_time), .o_fired_tag(o_fired_tag),
        .o_now_time(o_now_time), .o_pending(o_pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow of the queue
    logic [62:0] q_limit;
    logic [62:0] q_time [DEPTH];
    logic [15:0] q_tag [DEPTH];
    logic        q_valid [DEPTH];
    int          q_order [DEPTH];
    int          q_count;
    logic [62:0] q_now;

    req_t  pending_items[$];
    resp_t expected_results[$];
    int    idle_pct = 0;
    int    errors = 0;
    int    items_sent = 0;
    int    results_seen = 0;
    int    fired_seen = 0;
    int    limit_seen = 0;
    int    full_seen = 0;
    longint unsigned cycles = 0;

    task automatic queue_reset();
        q_limit = LIMIT_RESET;
        q_count = 0;
        q_now = '0;
        for (int i = 0; i < DEPTH; i++) begin
            q_valid[i] = 1'b0;
            q_order[i] = 0;
        end
    endtask

    function automatic void queue_drop(input int pos);
        for (int i = pos; i + 1 < q_count; i++) q_order[i] = q_order[i+1];
        q_count--;
    endfunction

    function automatic resp_t queue_apply(input req_t r);
        resp_t res;
        int fs, pos, head;
        res = '0;
        case (r.kind)
            K_SCHED: begin
                fs = 0;
                while (fs < DEPTH && q_valid[fs]) fs++;
                if (q_count >= DEPTH || fs >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < q_count && q_time[q_order[pos]] <= r.event_time) pos++;
                    for (int i = q_count; i > pos; i--) q_order[i] = q_order[i-1];
                    q_order[pos] = fs;
                    q_count++;
                    q_time[fs] = r.event_time;
                    q_tag[fs] = r.event_tag;
                    q_valid[fs] = 1'b1;
                    res.slot = fs[3:0];
                    res.status = ST_SCHEDULED;
                end
            end
            K_CANCEL: begin
                res.status = ST_NOT_FOUND;
                if (q_valid[r.handle]) begin
                    for (int p = 0; p < q_count; p++) begin
                        if (res.status == ST_NOT_FOUND && q_order[p] == int'(r.handle)) begin
                            queue_drop(p);
                            q_valid[r.handle] = 1'b0;
                            res.status = ST_CANCELLED;
                        end
                    end
                end
            end
            K_NEXT: begin
                if (q_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    head = q_order[0];
                    if (q_time[head] >= q_limit) begin
                        q_now = q_limit;
                        res.status = ST_LIMIT;
                    end else begin
                        queue_drop(0);
                        q_valid[head] = 1'b0;
                        q_now = q_time[head];
                        res.slot = head[3:0];
                        res.fired_time = q_time[head];
                        res.fired_tag = q_tag[head];
                        res.status = ST_FIRED;
                    end
                end
            end
            default: res.status = ST_NOT_FOUND;
        endcase
        res.now_time = q_now;
        res.pending = q_count[4:0];
        return res;
    endfunction

    // driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (!i_start || !o_busy) begin
                if (i_start) begin
                    expected_results.push_back(queue_apply({i_kind, i_event_time,
                                                            i_event_tag, i_handle}));
                    items_sent <= items_sent + 1;
                end
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    req_t r;
                    r = pending_items.pop_front();
                    i_start <= 1'b1;
                    i_kind <= r.kind;
                    i_event_time <= r.event_time;
                    i_event_tag <= r.event_tag;
                    i_handle <= r.handle;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            resp_t e;
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_status == ST_FIRED) fired_seen <= fired_seen + 1;
                if (o_status == ST_LIMIT) limit_seen <= limit_seen + 1;
                if (o_status == ST_FULL) full_seen <= full_seen + 1;
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); errors++;
                end
                if (o_slot !== e.slot) begin
                    $error("slot exp %0d got %0d", e.slot, o_slot); errors++;
                end
                if (o_fired_time !== e.fired_time) begin
                    $error("fired_time exp %0d got %0d", e.fired_time, o_fired_time);
                    errors++;
                end
                if (o_fired_tag !== e.fired_tag) begin
                    $error("fired_tag exp %0d got %0d", e.fired_tag, o_fired_tag);
                    errors++;
                end
                if (o_now_time !== e.now_time) begin
                    $error("now_time exp %0d got %0d", e.now_time, o_now_time);
                    errors++;
                end
                if (o_pending !== e.pending) begin
                    $error("pending exp %0d got %0d", e.pending, o_pending);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout");
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [62:0] rand_time63();
        return 63'({$urandom(), $urandom()});
    endfunction

    function automatic req_t make_item(input logic [1:0] k, input logic [62:0] t,
                                       input logic [15:0] g, input logic [3:0] h);
        req_t r;
        r.kind = k;
        r.event_time = t;
        r.event_tag = g;
        r.handle = h;
        return r;
    endfunction

    function automatic logic [62:0] near_time(input logic [62:0] base);
        case ($urandom_range(3))
            0: return base + 63'($urandom_range(40));
            1: return base + 63'($urandom_range(3));
            2: return rand_time63();
            default: return base;
        endcase
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || i_start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [62:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        q_limit = v;
    endtask

    task automatic fill_random(input int n, input logic [62:0] base);
        logic [1:0] k;
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 45) k = K_SCHED;
            else if (sel < 65) k = K_CANCEL;
            else if (sel < 97) k = K_NEXT;
            else k = K_UNUSED;
            pending_items.push_back(make_item(k, near_time(base), 16'($urandom()),
                                              4'($urandom_range(15))));
        end
    endtask

    initial begin
        queue_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty, unknown, full, extremes, equal times, limit
        pending_items.push_back(make_item(K_NEXT, '0, '0, '0));
        pending_items.push_back(make_item(K_CANCEL, '0, '0, 4'd15));
        pending_items.push_back(make_item(K_UNUSED, '1, '1, '1));
        for (int i = 0; i < 16; i++)
            pending_items.push_back(make_item(K_SCHED, (i == 0) ? '1 : 63'(i % 3),
                                              (i == 1) ? 16'hFFFF : 16'(i), '0));
        pending_items.push_back(make_item(K_SCHED, '0, 16'h1234, '0));
        pending_items.push_back(make_item(K_CANCEL, '0, '0, 4'd5));
        pending_items.push_back(make_item(K_CANCEL, '0, '0, 4'd5));
        pending_items.push_back(make_item(K_NEXT, '0, '0, '0));
        pending_items.push_back(make_item(K_NEXT, '0, '0, '0));
        drain();

        write_limit(63'd0);
        pending_items.push_back(make_item(K_NEXT, '0, '0, '0));
        drain();
        write_limit('1);
        for (int i = 0; i < 16; i++) pending_items.push_back(make_item(K_NEXT, '0, '0, '0));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1 || ph == 2) ? 67 : (ph == 3 ? 9 : 0);
            write_limit((ph == 0) ? LIMIT_RESET : 63'(1000 + $urandom_range(100)));
            fill_random(160, 63'(900 + $urandom_range(200)));
            drain();
        end
        idle_pct = 0;
        write_limit(63'h7FFF_FFFF_FFFF_FFFE);
        fill_random(20, rand_time63());
        drain();

        $display("items %0d, results %0d: fired %0d, limit stops %0d, full %0d",
                 items_sent, results_seen, fired_seen, limit_seen, full_seen);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/teq_pkg.sv
hw/rtl/teq_dp.sv
hw/rtl/teq_ctrl.sv
hw/rtl/timed_event_queue_unit.sv
dv/timed_event_queue_unit_tb.sv
